// ----- rtl/core/box_mean_blur_defines.svh -----
// Assertion macros for the box mean blur block
`ifndef BOX_MEAN_BLUR_DEFINES_SVH
`define BOX_MEAN_BLUR_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define BMB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/bmb_pkg.sv -----
// Shared types and constants for the box mean blur block
package bmb_pkg;
    localparam int unsigned REG_FRAME_WIDTH  = 0;
    localparam int unsigned REG_FRAME_HEIGHT = 1;
    localparam int unsigned REG_HALF_WIDTH   = 2;
    localparam int unsigned REG_HALF_HEIGHT  = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] blurred_value;
        logic       frame_last;
    } out_item_t;
endpackage

// ----- rtl/core/bmb_stream_if.sv -----
// Valid/ready channel carrying a payload
interface bmb_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/box_mean_blur.sv -----
// Box mean blur: top level with sequencer, line store and divider
//
// Usage: pixels enter on in_ch (kind 0 carries pixel_value, kind 1 is a
// drain tick), raster order. Each accepted request yields zero or one
// result on out_ch: the rounded mean of the clipped window of the next
// pending output position, with frame_last set on the frame's final pixel.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while idle, as the block does not enforce this.
// One request is worked at a time: a pixel is written into the line
// store, then one single-port store read is made per window pixel (up
// to (2dx+1)*(2dy+1) reads, 225 at most), then a bit-serial divide. A
// request with no result returns the block to idle from the check state.
// The result sits in an output register; the next request is accepted
// while it waits, but its result waits until the register frees.
// Reset clears the position counters, state and valid flags and loads
// the default configuration; the line store is not cleared and needs no
// clearing pass (it is always written before being read).
module box_mean_blur #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_RADIUS = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bmb_stream_if.sink                      in_ch,
    bmb_stream_if.source                    out_ch,
    input  logic                            cfg_we,
    input  logic [bmb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmb_pkg::CFG_DATA_W-1:0]  cfg_data
);
`include "box_mean_blur_defines.svh"

    // store rows rounded up to a power of two, columns to a power of two
    localparam int unsigned RW    = $clog2(2 * MAX_RADIUS + 2);
    localparam int unsigned CW    = $clog2(MAX_WIDTH);
    localparam int unsigned AW    = RW + CW;
    localparam int unsigned DEPTH = 1 << AW;
    localparam int unsigned SW    = 8 + $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int unsigned NW    = SW + 2;
    localparam int unsigned KW    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1) + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // configuration registers
    logic [10:0] fw_reg;
    logic [11:0] fh_reg;
    logic [2:0]  hw_reg, hh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= 11'd64;
            fh_reg <= 12'd64;
            hw_reg <= 3'd1;
            hh_reg <= 3'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bmb_pkg::CFG_IDX_W'(bmb_pkg::REG_FRAME_WIDTH):  fw_reg <= cfg_data[10:0];
                bmb_pkg::CFG_IDX_W'(bmb_pkg::REG_FRAME_HEIGHT): fh_reg <= cfg_data[11:0];
                bmb_pkg::CFG_IDX_W'(bmb_pkg::REG_HALF_WIDTH):   hw_reg <= cfg_data[2:0];
                bmb_pkg::CFG_IDX_W'(bmb_pkg::REG_HALF_HEIGHT):  hh_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // effective sizes (13-bit arithmetic)
    logic [12:0] w_eff, h_eff, dx, dy;
    always_comb
    begin
        if (fw_reg == 11'd0) w_eff = 13'd1;
        else if (13'(fw_reg) > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
        else w_eff = 13'(fw_reg);
        h_eff = (fh_reg == 12'd0) ? 13'd1 : 13'(fh_reg);
        dx = (13'(hw_reg) > 13'(MAX_RADIUS)) ? 13'(MAX_RADIUS) : 13'(hw_reg);
        dy = (13'(hh_reg) > 13'(MAX_RADIUS)) ? 13'(MAX_RADIUS) : 13'(hh_reg);
    end

    logic [2:0]  st_reg;
    logic [12:0] in_col_reg, in_row_reg, out_col_reg, out_row_reg;
    logic        recv_reg;
    logic [12:0] y_reg, x_reg, y1_reg, x0_reg, x1_reg;
    logic [SW-1:0] sum_reg;
    logic [KW-1:0] cnt_reg;
    logic        rd_valid_reg, rd_last_reg, last_reg;
    logic        ovalid_reg;
    logic [7:0]  oval_reg;
    logic        olast_reg;

    // window bounds for the pending output
    logic [12:0] ry, cx, y0, x0;
    logic        ready_now;
    always_comb
    begin
        ry = (out_row_reg + dy > h_eff - 13'd1) ? h_eff - 13'd1 : out_row_reg + dy;
        cx = (out_col_reg + dx > w_eff - 13'd1) ? w_eff - 13'd1 : out_col_reg + dx;
        y0 = (out_row_reg > dy) ? out_row_reg - dy : 13'd0;
        x0 = (out_col_reg > dx) ? out_col_reg - dx : 13'd0;
        ready_now = recv_reg || (in_row_reg > ry) || (in_row_reg == ry && in_col_reg > cx);
    end

    // store address: low row bits select the row slot, then the column
    function automatic logic [AW-1:0] st_addr(input logic [12:0] r, input logic [12:0] c);
        return {r[RW-1:0], c[CW-1:0]};
    endfunction

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_rdata;
    logic          take;

    assign take = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (st_reg == ST_IDLE);

    always_comb
    begin
        ram_we   = 1'b0;
        ram_addr = st_addr(y_reg, x_reg);
        if (take && in_ch.payload.kind == bmb_pkg::KIND_PIXEL && !recv_reg)
        begin
            ram_we   = 1'b1;
            ram_addr = st_addr(in_row_reg, in_col_reg);
        end
    end

    bmb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
        .clk(clk), .we(ram_we), .addr(ram_addr),
        .wdata(in_ch.payload.pixel_value), .rdata(ram_rdata)
    );

    // divider for floor((2*sum+count)/(2*count))
    logic          div_start_reg, div_go, div_done;
    logic [NW-1:0] div_q;
    logic [NW-1:0] div_n;
    logic [KW-1:0] div_d;
    assign div_n = {sum_reg, 1'b0} + NW'(cnt_reg);
    assign div_d = {cnt_reg[KW-2:0], 1'b0};

    // start on an empty window or once the last store read has been summed
    assign div_go = (st_reg == ST_CHECK && ready_now && (y0 > ry || x0 > cx))
                    || (st_reg == ST_READ && rd_last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= div_go;
        end
    end

    bmb_divider #(.NW(NW), .DW(KW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start_reg),
        .numer(div_n), .denom(div_d), .done(div_done), .quot(div_q)
    );

    logic read_end;
    assign read_end = (x_reg >= x1_reg) && (y_reg >= y1_reg);

    // output register load and release
    logic load_out;
    assign load_out = (st_reg == ST_OUT) && (!ovalid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            recv_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
        end
        else
        begin
            case (st_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        if (in_ch.payload.kind == bmb_pkg::KIND_PIXEL && !recv_reg)
                        begin
                            if (in_col_reg + 13'd1 >= w_eff)
                            begin
                                in_col_reg <= '0;
                                if (in_row_reg + 13'd1 >= h_eff)
                                begin
                                    in_row_reg <= '0;
                                    recv_reg   <= 1'b1;
                                end
                                else
                                begin
                                    in_row_reg <= in_row_reg + 13'd1;
                                end
                            end
                            else
                            begin
                                in_col_reg <= in_col_reg + 13'd1;
                            end
                        end
                        st_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    y_reg   <= y0;
                    x_reg   <= x0;
                    x0_reg  <= x0;
                    x1_reg  <= cx;
                    y1_reg  <= ry;
                    sum_reg <= '0;
                    cnt_reg <= '0;
                    rd_valid_reg <= 1'b0;
                    rd_last_reg  <= 1'b0;
                    if (!ready_now)
                    begin
                        st_reg <= ST_IDLE;
                    end
                    else
                    begin
                        // advance output position now; window bounds are latched
                        last_reg <= (out_col_reg + 13'd1 >= w_eff)
                                    && (out_row_reg + 13'd1 >= h_eff);
                        if (out_col_reg + 13'd1 >= w_eff)
                        begin
                            out_col_reg <= '0;
                            if (out_row_reg + 13'd1 >= h_eff)
                            begin
                                out_row_reg <= '0;
                                in_col_reg  <= '0;
                                in_row_reg  <= '0;
                                recv_reg    <= 1'b0;
                            end
                            else
                            begin
                                out_row_reg <= out_row_reg + 13'd1;
                            end
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + 13'd1;
                        end
                        if (y0 > ry || x0 > cx)
                        begin
                            st_reg <= ST_DIV;
                        end
                        else
                        begin
                            st_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    // issue one read per cycle, accumulate the returning data
                    if (rd_valid_reg)
                    begin
                        sum_reg <= sum_reg + SW'(ram_rdata);
                        cnt_reg <= cnt_reg + KW'(1);
                    end
                    if (rd_last_reg)
                    begin
                        rd_valid_reg <= 1'b0;
                        st_reg    <= ST_DIV;
                    end
                    else
                    begin
                        rd_valid_reg <= 1'b1;
                        rd_last_reg  <= read_end;
                        if (x_reg >= x1_reg)
                        begin
                            x_reg <= x0_reg;
                            y_reg <= y_reg + 13'd1;
                        end
                        else
                        begin
                            x_reg <= x_reg + 13'd1;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        st_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (load_out)
                    begin
                        if (cnt_reg == '0) oval_reg <= 8'd0;
                        else if (div_q > NW'(255)) oval_reg <= 8'd255;
                        else oval_reg <= div_q[7:0];
                        olast_reg <= last_reg;
                        st_reg    <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.payload.blurred_value = oval_reg;
    assign out_ch.payload.frame_last = olast_reg;

    // checks on the sequencer
    `BMB_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, st_reg == ST_IDLE)
    `BMB_ASSERT_NEXT(a_take_check, clk, rst_n, take, st_reg == ST_CHECK)
    `BMB_ASSERT_IMP(a_div_in_div, clk, rst_n, div_done, st_reg == ST_DIV)
endmodule

// ----- rtl/core/bmb_ram.sv -----
// Generic single-port synchronous RAM with registered read
module bmb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- rtl/core/bmb_divider.sv -----
// Restoring divider: quotient of a sum by a count, one bit per cycle
module bmb_divider #(
    parameter int unsigned NW = 18,
    parameter int unsigned DW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [DW:0]   trial;

    // one shift-subtract step per cycle
    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = numer;
            rem_next  = '0;
            den_next  = denom;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg[DW-1:0], q_reg[NW-1]};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

// ----- test/tb_box_mean_blur.sv -----
// Testbench for box_mean_blur: streams frames and checks each blurred pixel
module tb_box_mean_blur;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_W      = 1024;
    localparam int unsigned MAX_R      = 7;
    localparam int unsigned STORE_ROWS = 2 * MAX_R + 2;
    localparam int unsigned SETTLE     = 300;
    localparam int unsigned LIMIT      = 1000000;
    localparam int unsigned HOLD_LEN   = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [bmb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bmb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    bmb_stream_if #(.payload_t(bmb_pkg::in_item_t))  in_ch();
    bmb_stream_if #(.payload_t(bmb_pkg::out_item_t)) out_ch();

    box_mean_blur DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Shadow of the block: registers, counters and line store
    logic [7:0]  shadow_store [0:STORE_ROWS*MAX_W-1];
    logic [10:0] reg_width  = 11'd64;
    logic [11:0] reg_height = 12'd64;
    logic [2:0]  reg_dx = 3'd1;
    logic [2:0]  reg_dy = 3'd1;
    int unsigned in_col, in_row, out_col, out_row;
    bit          frame_done;
    int unsigned frames_closed = 0;

    bmb_pkg::out_item_t pending_means [$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    bit          gaps_on = 1'b1;
    int unsigned hold_asked = 0;
    int unsigned items_sent = 0;

    function automatic int unsigned store_addr(int unsigned row, int unsigned col);
        return (row % STORE_ROWS) * MAX_W + (col % MAX_W);
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Predict the result of one accepted request
    task automatic blur_predict(input bmb_pkg::in_item_t req);
        int unsigned w, h, dx, dy, ry, cx, y0, x0, sum, cnt, mean;
        bmb_pkg::out_item_t res;
        w  = (reg_width == 0) ? 1 : ((reg_width > MAX_W) ? MAX_W : reg_width);
        h  = (reg_height == 0) ? 1 : reg_height;
        dx = (reg_dx > MAX_R) ? MAX_R : reg_dx;
        dy = (reg_dy > MAX_R) ? MAX_R : reg_dy;
        if (req.kind == bmb_pkg::KIND_PIXEL && !frame_done)
        begin
            shadow_store[store_addr(in_row, in_col)] = req.pixel_value;
            if (in_col + 1 >= w)
            begin
                in_col = 0;
                if (in_row + 1 >= h)
                begin
                    in_row = 0;
                    frame_done = 1'b1;
                end
                else
                    in_row++;
            end
            else
                in_col++;
        end
        ry = (out_row + dy > h - 1) ? h - 1 : out_row + dy;
        cx = (out_col + dx > w - 1) ? w - 1 : out_col + dx;
        if (!(frame_done || in_row > ry || (in_row == ry && in_col > cx)))
            return;
        y0 = (out_row > dy) ? out_row - dy : 0;
        x0 = (out_col > dx) ? out_col - dx : 0;
        sum = 0;
        cnt = 0;
        for (int unsigned y = y0; y <= ry; y++)
            for (int unsigned x = x0; x <= cx; x++)
            begin
                sum += shadow_store[store_addr(y, x)];
                cnt++;
            end
        mean = (cnt != 0) ? (2 * sum + cnt) / (2 * cnt) : 0;
        if (mean > 255)
            mean = 255;
        res.blurred_value = mean[7:0];
        res.frame_last    = 1'b0;
        if (out_col + 1 >= w)
        begin
            out_col = 0;
            if (out_row + 1 >= h)
            begin
                res.frame_last = 1'b1;
                out_row = 0;
                in_col = 0;
                in_row = 0;
                frame_done = 1'b0;
                frames_closed++;
            end
            else
                out_row++;
        end
        else
            out_col++;
        pending_means.push_back(res);
    endtask

    // Send one request and wait for its acceptance
    task automatic send_item(input logic kind, input logic [7:0] value);
        bmb_pkg::in_item_t req;
        int unsigned gap;
        req.kind        = kind;
        req.pixel_value = value;
        in_ch.valid   <= 1'b1;
        in_ch.payload <= req;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        blur_predict(req);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait until every expected result has come, then let the block settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input int unsigned idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx[bmb_pkg::CFG_IDX_W-1:0];
        cfg_data  <= value[bmb_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bmb_pkg::REG_FRAME_WIDTH:  reg_width  = value[10:0];
            bmb_pkg::REG_FRAME_HEIGHT: reg_height = value[11:0];
            bmb_pkg::REG_HALF_WIDTH:   reg_dx     = value[2:0];
            bmb_pkg::REG_HALF_HEIGHT:  reg_dy     = value[2:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h,
                             input int unsigned dx, input int unsigned dy);
        wait_idle();
        write_reg(bmb_pkg::REG_FRAME_WIDTH, w);
        write_reg(bmb_pkg::REG_FRAME_HEIGHT, h);
        write_reg(bmb_pkg::REG_HALF_WIDTH, dx);
        write_reg(bmb_pkg::REG_HALF_HEIGHT, dy);
    endtask

    function automatic logic [7:0] pick_pixel();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // Stream one whole frame; noise mixes in stray drains
    task automatic run_frame(input int unsigned noise);
        int unsigned start;
        start = frames_closed;
        while (frames_closed == start && !frame_done)
        begin
            if ($urandom_range(0, 99) < noise)
                send_item(bmb_pkg::KIND_DRAIN, 8'($urandom_range(0, 255)));
            else
                send_item(bmb_pkg::KIND_PIXEL, pick_pixel());
        end
        // after the last pixel: drains, or pixels that act as drains
        while (frames_closed == start)
            send_item(($urandom_range(0, 1) != 0) ? bmb_pkg::KIND_DRAIN : bmb_pkg::KIND_PIXEL,
                      pick_pixel());
    endtask

    // Drains straight after reset give nothing
    task automatic test_idle_drains();
        repeat (3) send_item(bmb_pkg::KIND_DRAIN, 8'hFF);
        send_item(bmb_pkg::KIND_DRAIN, 8'h00);
    endtask

    // Small directed frames: extreme values, zero sizes and the largest radius
    task automatic test_directed();
        set_frame(3, 2, 0, 0);
        send_item(bmb_pkg::KIND_PIXEL, 8'd0);
        send_item(bmb_pkg::KIND_PIXEL, 8'd255);
        send_item(bmb_pkg::KIND_DRAIN, 8'd0);
        send_item(bmb_pkg::KIND_PIXEL, 8'd255);
        send_item(bmb_pkg::KIND_PIXEL, 8'd0);
        send_item(bmb_pkg::KIND_PIXEL, 8'd1);
        // zero sizes mean one pixel, radius beyond the frame
        set_frame(0, 0, 7, 7);
        send_item(bmb_pkg::KIND_PIXEL, 8'd200);
        // rounding: 2x2 frame of 0,1,1,0, whose windows each hold all four pixels
        set_frame(2, 2, 1, 1);
        send_item(bmb_pkg::KIND_PIXEL, 8'd0);
        send_item(bmb_pkg::KIND_PIXEL, 8'd1);
        send_item(bmb_pkg::KIND_PIXEL, 8'd1);
        send_item(bmb_pkg::KIND_DRAIN, 8'd0);
        send_item(bmb_pkg::KIND_PIXEL, 8'd0);
        send_item(bmb_pkg::KIND_PIXEL, 8'd77);
        send_item(bmb_pkg::KIND_DRAIN, 8'd0);
        send_item(bmb_pkg::KIND_DRAIN, 8'd0);
        send_item(bmb_pkg::KIND_DRAIN, 8'd0);
    endtask

    // Largest radii on a wide frame, tall single-column frame
    task automatic test_extreme_sizes();
        set_frame(64, 2, 7, 7);
        run_frame(0);
        set_frame(1, 40, 0, 7);
        run_frame(0);
    endtask

    // Receiver holds off while the sender keeps offering requests
    task automatic test_backpressure();
        set_frame(8, 5, 1, 2);
        hold_asked++;
        run_frame(5);
    endtask

    task automatic test_random();
        int unsigned w, h, start;
        start = items_sent;
        while (items_sent - start < 250)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            gaps_on = ($urandom_range(0, 3) != 0);
            set_frame(w, h, $urandom_range(0, 7), $urandom_range(0, 7));
            run_frame($urandom_range(0, 3) == 0 ? 0 : 10);
        end
        gaps_on = 1'b1;
    endtask

    // Receiver: random stalls plus the long hold-off
    always @(posedge clk)
    begin
        static int unsigned stall_left = 0;
        static int unsigned hold_seen = 0;
        if (hold_seen != hold_asked)
        begin
            hold_seen = hold_asked;
            stall_left = HOLD_LEN;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < 20)
                stall_left = pick_gap();
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        bmb_pkg::out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_means.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, out_ch.payload);
                errors++;
            end
            else
            begin
                want = pending_means.pop_front();
                if (want.blurred_value !== out_ch.payload.blurred_value)
                begin
                    $display("%0t: blurred_value expected %0d actual %0d", $time,
                             want.blurred_value, out_ch.payload.blurred_value);
                    errors++;
                end
                if (want.frame_last !== out_ch.payload.frame_last)
                begin
                    $display("%0t: frame_last expected %0d actual %0d", $time,
                             want.frame_last, out_ch.payload.frame_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        for (int i = 0; i < STORE_ROWS * MAX_W; i++)
            shadow_store[i] = 8'd0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        frame_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_drains();
        test_directed();
        test_backpressure();
        test_random();
        test_extreme_sizes();
        wait_idle();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
